### hw/rtl/obpt_pkg.sv
// shared types, constants and helpers for the oriented box pose transform
// no dependencies
package obpt_pkg;

   localparam int POS_FRAC_BITS   = 16;
   localparam int QUAT_FRAC_BITS  = 14;
   localparam int SCALE_FRAC_BITS = 8;

   // rounded matrix entry: |2*(ab+cd)| <= 2^32 before the shift
   localparam int MAT_W  = 34 - QUAT_FRAC_BITS;
   localparam int ENT_W  = 36;
   localparam int PT_W   = 33;
   localparam int SP_W   = PT_W + 16;
   localparam int PROD_W = MAT_W + 32;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RND_W  = ACC_W - QUAT_FRAC_BITS;

   typedef logic [3:0]                kind_type;
   typedef logic signed [31:0]        word_type;
   typedef logic signed [15:0]        half_word_type;
   typedef logic signed [MAT_W-1:0]   mat_type;
   typedef logic signed [PT_W-1:0]    pt_type;

   localparam kind_type KIND_CENTER  = 4'd3;
   localparam kind_type KIND_CORNER0 = 4'd4;
   localparam kind_type KIND_LAST    = 4'd11;

   typedef enum logic [2:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_HALF_X   = 3'd3,
      CSR_HALF_Y   = 3'd4,
      CSR_HALF_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      half_word_type quat_w;
      half_word_type quat_x;
      half_word_type quat_y;
      half_word_type quat_z;
      word_type      pos_x;
      word_type      pos_y;
      word_type      pos_z;
      half_word_type scale_x;
      half_word_type scale_y;
      half_word_type scale_z;
   } req_type;

   typedef struct packed {
      kind_type item_kind;
      word_type out_x;
      word_type out_y;
      word_type out_z;
      logic     last;
   } rsp_type;

   // m[c][r]: column c, row r
   typedef struct packed {
      mat_type [2:0][2:0]      m;
      word_type [2:0]          pos;
      half_word_type [2:0]     scale;
   } pose_type;

   function automatic word_type sat32(input logic signed [63:0] v);
      word_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic word_type qf_to_pos(input mat_type m);
      logic signed [63:0] e;
      e = 64'(m);
      if (POS_FRAC_BITS >= QUAT_FRAC_BITS) begin
         e = e <<< (POS_FRAC_BITS - QUAT_FRAC_BITS);
      end else begin
         e = (e + (64'sd1 <<< (QUAT_FRAC_BITS - POS_FRAC_BITS - 1)))
             >>> (QUAT_FRAC_BITS - POS_FRAC_BITS);
      end
      return sat32(e);
   endfunction

endpackage

### hw/rtl/obpt_quat_matrix.sv
// quaternion to rotation matrix front end, two register stages
// depends on obpt_pkg
module obpt_quat_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  obpt_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output obpt_pkg::pose_type out_pose
);
   import obpt_pkg::*;

   typedef struct packed {
      logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   } prods_type;

   prods_type          prod_ff, prod_in;
   word_type [2:0]     pos_ff;
   half_word_type [2:0] scale_ff;
   logic               f1_valid_ff;
   logic               f2_valid_ff;
   logic               f1_ready, f2_ready;
   pose_type           pose_ff, pose_in;
   logic signed [ENT_W-1:0] ent [3][3];
   logic signed [ENT_W-1:0] one;

   assign f2_ready = !f2_valid_ff || out_ready;
   assign f1_ready = !f1_valid_ff || f2_ready;
   assign in_ready = f1_ready;

   always_comb begin
      prod_in.xx = in_data.quat_x * in_data.quat_x;
      prod_in.yy = in_data.quat_y * in_data.quat_y;
      prod_in.zz = in_data.quat_z * in_data.quat_z;
      prod_in.xy = in_data.quat_x * in_data.quat_y;
      prod_in.xz = in_data.quat_x * in_data.quat_z;
      prod_in.yz = in_data.quat_y * in_data.quat_z;
      prod_in.wx = in_data.quat_w * in_data.quat_x;
      prod_in.wy = in_data.quat_w * in_data.quat_y;
      prod_in.wz = in_data.quat_w * in_data.quat_z;
   end

   always_comb begin
      one = ENT_W'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
      ent[0][0] = one - 2 * (ENT_W'(prod_ff.yy) + ENT_W'(prod_ff.zz));
      ent[0][1] = 2 * (ENT_W'(prod_ff.xy) + ENT_W'(prod_ff.wz));
      ent[0][2] = 2 * (ENT_W'(prod_ff.xz) - ENT_W'(prod_ff.wy));
      ent[1][0] = 2 * (ENT_W'(prod_ff.xy) - ENT_W'(prod_ff.wz));
      ent[1][1] = one - 2 * (ENT_W'(prod_ff.xx) + ENT_W'(prod_ff.zz));
      ent[1][2] = 2 * (ENT_W'(prod_ff.yz) + ENT_W'(prod_ff.wx));
      ent[2][0] = 2 * (ENT_W'(prod_ff.xz) + ENT_W'(prod_ff.wy));
      ent[2][1] = 2 * (ENT_W'(prod_ff.yz) - ENT_W'(prod_ff.wx));
      ent[2][2] = one - 2 * (ENT_W'(prod_ff.xx) + ENT_W'(prod_ff.yy));
      pose_in.pos   = pos_ff;
      pose_in.scale = scale_ff;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            // round half up to the quaternion fraction
            pose_in.m[c][r] = MAT_W'((ent[c][r] + (ENT_W'(1) <<< (QUAT_FRAC_BITS - 1)))
                                     >>> QUAT_FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         if (f1_ready) begin
            f1_valid_ff <= in_valid;
         end
         if (f2_ready) begin
            f2_valid_ff <= f1_valid_ff;
         end
      end
      if (f1_ready && in_valid) begin
         prod_ff  <= prod_in;
         pos_ff   <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
         scale_ff <= {in_data.scale_z, in_data.scale_y, in_data.scale_x};
      end
      if (f2_ready && f1_valid_ff) begin
         pose_ff <= pose_in;
      end
   end

   assign out_valid = f2_valid_ff;
   assign out_pose  = pose_ff;

endmodule

### hw/rtl/oriented_box_pose_transform.sv
// oriented box pose transform top level: csr bank, result sequencer, point pipeline
// depends on obpt_pkg and obpt_quat_matrix
// path: the first result of a pose is registered in the matrix front end, then in point stages j1 to j5
// throughput: one result per cycle while rsp_ready is high and a pose is held; the sequencer
// issues the twelve results of the held pose in order
// reset clears all valid bits and the sequencer; center resets to 0, half extents to 0.5
module oriented_box_pose_transform (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  obpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output obpt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import obpt_pkg::*;

   word_type [2:0]    center_ff;
   logic [2:0][30:0]  half_ff;

   logic      pose_valid, pose_ready;
   pose_type  pose;
   kind_type  cnt_ff;
   logic      issue;

   // stage 1: local point
   logic              j1_valid_ff;
   kind_type          j1_kind_ff;
   pt_type [2:0]      j1_pt_ff, j1_pt_in;
   pose_type          j1_pose_ff;
   // stage 2: scaled point
   logic              j2_valid_ff;
   kind_type          j2_kind_ff;
   word_type [2:0]    j2_sp_ff, j2_sp_in;
   mat_type [2:0][2:0] j2_m_ff;
   word_type [2:0]    j2_pos_ff;
   // stage 3: matrix products
   logic              j3_valid_ff;
   kind_type          j3_kind_ff;
   logic signed [PROD_W-1:0] j3_prod_ff [3][3];
   word_type [2:0]    j3_pos_ff;
   word_type [2:0]    j3_axis_ff, j3_axis_in;
   // stage 4: rounded row sums
   logic              j4_valid_ff;
   kind_type          j4_kind_ff;
   logic signed [RND_W-1:0] j4_rnd_ff [3];
   logic signed [RND_W-1:0] j4_rnd_in [3];
   word_type [2:0]    j4_pos_ff;
   word_type [2:0]    j4_axis_ff;
   // stage 5: output register
   logic              j5_valid_ff;
   rsp_type           j5_rsp_ff, j5_rsp_in;

   logic j1_ready, j2_ready, j3_ready, j4_ready, j5_ready;
   logic [2:0]        cv;
   logic [2:0]        plus;
   logic signed [SP_W-1:0]  sp_prod [3];
   logic signed [ACC_W-1:0] acc [3];
   logic signed [RND_W:0]   res [3];
   word_type [2:0]    outv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= {3{31'd32768}};
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_ff[0] <= csr_wdata;
            CSR_CENTER_Y: center_ff[1] <= csr_wdata;
            CSR_CENTER_Z: center_ff[2] <= csr_wdata;
            CSR_HALF_X:   half_ff[0]   <= csr_wdata[30:0];
            CSR_HALF_Y:   half_ff[1]   <= csr_wdata[30:0];
            CSR_HALF_Z:   half_ff[2]   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   obpt_quat_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (pose_valid),
      .out_ready (pose_ready),
      .out_pose  (pose)
   );

   assign j5_ready = !j5_valid_ff || rsp_ready;
   assign j4_ready = !j4_valid_ff || j5_ready;
   assign j3_ready = !j3_valid_ff || j4_ready;
   assign j2_ready = !j2_valid_ff || j3_ready;
   assign j1_ready = !j1_valid_ff || j2_ready;

   assign issue      = pose_valid && j1_ready;
   assign pose_ready = issue && (cnt_ff == KIND_LAST);

   // corner sign pattern: x follows v[1]^v[0], y v[1], z v[2]
   always_comb begin
      cv = 3'(cnt_ff - KIND_CORNER0);
      plus = {cv[2], cv[1], cv[1] ^ cv[0]};
      for (int i = 0; i < 3; i++) begin
         if (cnt_ff == KIND_CENTER) begin
            j1_pt_in[i] = PT_W'(center_ff[i]);
         end else if (plus[i]) begin
            j1_pt_in[i] = PT_W'(center_ff[i]) + PT_W'({1'b0, half_ff[i]});
         end else begin
            j1_pt_in[i] = PT_W'(center_ff[i]) - PT_W'({1'b0, half_ff[i]});
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sp_prod[i] = j1_pt_ff[i] * j1_pose_ff.scale[i];
         j2_sp_in[i] = sat32(64'((sp_prod[i] + (SP_W'(1) <<< (SCALE_FRAC_BITS - 1)))
                                 >>> SCALE_FRAC_BITS));
      end
   end

   always_comb begin
      j3_axis_in = '0;
      for (int c = 0; c < 3; c++) begin
         if (j2_kind_ff == kind_type'(c)) begin
            for (int r = 0; r < 3; r++) begin
               j3_axis_in[r] = qf_to_pos(j2_m_ff[c][r]);
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC_W'(j3_prod_ff[0][r]) + ACC_W'(j3_prod_ff[1][r])
                + ACC_W'(j3_prod_ff[2][r]);
         j4_rnd_in[r] = RND_W'((acc[r] + (ACC_W'(1) <<< (QUAT_FRAC_BITS - 1)))
                               >>> QUAT_FRAC_BITS);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         res[r]  = (RND_W+1)'(j4_pos_ff[r]) + (RND_W+1)'(j4_rnd_ff[r]);
         outv[r] = (j4_kind_ff < KIND_CENTER) ? j4_axis_ff[r] : sat32(64'(res[r]));
      end
      j5_rsp_in.item_kind = j4_kind_ff;
      j5_rsp_in.out_x     = outv[0];
      j5_rsp_in.out_y     = outv[1];
      j5_rsp_in.out_z     = outv[2];
      j5_rsp_in.last      = (j4_kind_ff == KIND_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         j1_valid_ff <= 1'b0;
         j2_valid_ff <= 1'b0;
         j3_valid_ff <= 1'b0;
         j4_valid_ff <= 1'b0;
         j5_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            cnt_ff <= (cnt_ff == KIND_LAST) ? '0 : cnt_ff + 4'd1;
         end
         if (j1_ready) j1_valid_ff <= issue;
         if (j2_ready) j2_valid_ff <= j1_valid_ff;
         if (j3_ready) j3_valid_ff <= j2_valid_ff;
         if (j4_ready) j4_valid_ff <= j3_valid_ff;
         if (j5_ready) j5_valid_ff <= j4_valid_ff;
      end
      if (issue) begin
         j1_kind_ff <= cnt_ff;
         j1_pt_ff   <= j1_pt_in;
         j1_pose_ff <= pose;
      end
      if (j2_ready && j1_valid_ff) begin
         j2_kind_ff <= j1_kind_ff;
         j2_sp_ff   <= j2_sp_in;
         j2_m_ff    <= j1_pose_ff.m;
         j2_pos_ff  <= j1_pose_ff.pos;
      end
      if (j3_ready && j2_valid_ff) begin
         j3_kind_ff <= j2_kind_ff;
         j3_pos_ff  <= j2_pos_ff;
         j3_axis_ff <= j3_axis_in;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               j3_prod_ff[c][r] <= j2_m_ff[c][r] * j2_sp_ff[c];
            end
         end
      end
      if (j4_ready && j3_valid_ff) begin
         j4_kind_ff <= j3_kind_ff;
         j4_pos_ff  <= j3_pos_ff;
         j4_axis_ff <= j3_axis_ff;
         for (int r = 0; r < 3; r++) begin
            j4_rnd_ff[r] <= j4_rnd_in[r];
         end
      end
      if (j5_ready && j4_valid_ff) begin
         j5_rsp_ff <= j5_rsp_in;
      end
   end

   assign rsp_valid = j5_valid_ff;
   assign rsp_data  = j5_rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= KIND_LAST) else $error("sequencer count out of range");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.item_kind == KIND_LAST)))
      else $error("last flag does not match kind");
   a_pose_release: assert property (@(posedge clock) disable iff (reset)
      pose_ready |=> (cnt_ff == '0)) else $error("pose released mid sequence");
   a_issue_step: assert property (@(posedge clock) disable iff (reset)
      (issue && cnt_ff != KIND_LAST) |=> (j1_kind_ff + 4'd1 == cnt_ff))
      else $error("sequencer skipped a result");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result valid right after reset");

endmodule
